// ===== hdl/uvf_pkg.sv =====
package uvf_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int VAL_W     = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_LOADI,
        ST_SCAN,
        ST_DECIDE,
        ST_FINISH
    } uvf_state_t;

endpackage

// ===== hdl/unique_value_filter.sv =====
// Channel  Direction  Ports                       Contents
// s_       in         tvalid tready tdata tlast    tdata: value; tlast: is_last
// m_       out        tvalid tready tdata tlast    tdata: value_res; tlast: is_last_res;
//                     tuser                        tuser: empty_res, overflow
// Items of a list are taken one per cycle while the block is idle.
// After the last item, each stored entry is checked against every other stored entry
// through the single read port of the value store before the block is ready for the next list.
// Reset is synchronous and active low; the store itself is not cleared.
// A stalled result register holds the scan until it has been taken.
module unique_value_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value_res
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // [0] empty_res, [1] overflow
);

    localparam int IW = uvf_pkg::IDX_W;
    localparam int CW = uvf_pkg::CNT_W;
    localparam int VW = uvf_pkg::VAL_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(uvf_pkg::MAX_ITEMS);

    uvf_pkg::uvf_state_t state_reg, state_next;

    logic [VW-1:0] mem [uvf_pkg::MAX_ITEMS];
    logic [VW-1:0] rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic          mem_we;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] k_reg, k_next;
    logic          chk_reg, chk_next;
    logic [CW-1:0] chk_idx_reg, chk_idx_next;
    logic          dup_reg, dup_next;
    logic signed [VW-1:0] cur_reg, cur_next;
    logic          pend_valid_reg, pend_valid_next;
    logic signed [VW-1:0] pend_reg, pend_next;
    logic          out_valid_reg, out_valid_next;
    logic signed [VW-1:0] out_data_reg, out_data_next;
    logic          out_last_reg, out_last_next;
    logic          out_empty_reg, out_empty_next;
    logic          out_ovf_reg, out_ovf_next;

    logic acc;
    logic out_free;

    assign acc      = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_ovf_reg, out_empty_reg};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[count_reg[IW-1:0]] <= s_tdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            uvf_pkg::ST_IDLE: begin
                if (acc && s_tlast) begin
                    state_next = uvf_pkg::ST_START;
                end
            end
            uvf_pkg::ST_START: begin
                state_next = (i_reg == count_reg) ? uvf_pkg::ST_FINISH : uvf_pkg::ST_LOADI;
            end
            uvf_pkg::ST_LOADI: begin
                state_next = uvf_pkg::ST_SCAN;
            end
            uvf_pkg::ST_SCAN: begin
                if (k_reg == count_reg && chk_reg) begin
                    state_next = uvf_pkg::ST_DECIDE;
                end
            end
            uvf_pkg::ST_DECIDE: begin
                if (dup_reg || !pend_valid_reg || out_free) begin
                    state_next = uvf_pkg::ST_START;
                end
            end
            uvf_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = uvf_pkg::ST_IDLE;
                end
            end
            default: state_next = uvf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        rd_addr  = '0;
        case (state_reg)
            uvf_pkg::ST_IDLE:  s_tready = 1'b1;
            uvf_pkg::ST_START: rd_addr  = i_reg[IW-1:0];
            uvf_pkg::ST_SCAN:  rd_addr  = k_reg[IW-1:0];
            default: begin
                s_tready = 1'b0;
                rd_addr  = '0;
            end
        endcase
        mem_we = acc && (count_reg < MAX_CNT);
    end

    always_comb begin
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        chk_next        = chk_reg;
        chk_idx_next    = chk_idx_reg;
        dup_next        = dup_reg;
        cur_next        = cur_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;
        out_ovf_next    = out_ovf_reg;
        case (state_reg)
            uvf_pkg::ST_IDLE: begin
                if (acc) begin
                    if (count_reg < MAX_CNT) begin
                        count_next = count_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    i_next          = '0;
                    pend_valid_next = 1'b0;
                end
            end
            uvf_pkg::ST_LOADI: begin
                cur_next = rd_data_reg;
                k_next   = '0;
                chk_next = 1'b0;
                dup_next = 1'b0;
            end
            uvf_pkg::ST_SCAN: begin
                if (chk_reg && rd_data_reg == cur_reg && chk_idx_reg != i_reg) begin
                    dup_next = 1'b1;
                end
                if (k_reg < count_reg) begin
                    chk_next     = 1'b1;
                    chk_idx_next = k_reg;
                    k_next       = k_reg + 1'b1;
                end else begin
                    chk_next = 1'b0;
                end
            end
            uvf_pkg::ST_DECIDE: begin
                if (dup_reg) begin
                    i_next = i_reg + 1'b1;
                end else if (!pend_valid_reg) begin
                    pend_next       = cur_reg;
                    pend_valid_next = 1'b1;
                    i_next          = i_reg + 1'b1;
                end else if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = pend_reg;
                    out_last_next  = 1'b0;
                    out_empty_next = 1'b0;
                    out_ovf_next   = ovf_reg;
                    pend_next      = cur_reg;
                    i_next         = i_reg + 1'b1;
                end
            end
            uvf_pkg::ST_FINISH: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_data_next   = pend_valid_reg ? pend_reg : '0;
                    out_last_next   = 1'b1;
                    out_empty_next  = !pend_valid_reg;
                    out_ovf_next    = ovf_reg;
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                end
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= uvf_pkg::ST_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            i_reg          <= '0;
            k_reg          <= '0;
            chk_reg        <= 1'b0;
            dup_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            i_reg          <= i_next;
            k_reg          <= k_next;
            chk_reg        <= chk_next;
            dup_reg        <= dup_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_idx_reg   <= chk_idx_next;
        cur_reg       <= cur_next;
        pend_reg      <= pend_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
    end

endmodule

// ===== hdl/uvf_checker.sv =====
module uvf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result changed");

    // The empty marker is the only result of its run and carries a zero value.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && m_tdata == 32'd0)
        else $error("malformed empty marker");

    // Once the final request of a list is taken, no further request is taken.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("request taken during scan");

    // All results of one run carry the same overflow flag.
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !m_tvalid || m_tuser[1] == $past(m_tuser[1]))
        else $error("overflow flag changed within a run");

endmodule

bind unique_value_filter uvf_checker u_uvf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
